### sv/running_average_filter_assert.svh
// Assertion macros for the running average filter.
`ifndef RUNNING_AVERAGE_FILTER_ASSERT_SVH
`define RUNNING_AVERAGE_FILTER_ASSERT_SVH

// Same-cycle implication.
`define RAF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RAF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/raf_pkg.sv
// Shared constants and types for the running average filter.
package raf_pkg;

   localparam int WINDOW = 20;
   localparam int AVG_W  = 16;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = AVG_W + $clog2(WINDOW);
   localparam int STEP_W = $clog2(SUM_W + 1);

   typedef struct packed {
      logic capture;
      logic update;
      logic load_out;
   } raf_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } raf_status_type;

endpackage

### sv/raf_div.sv
// Restoring divider, one quotient bit per cycle.
`include "running_average_filter_assert.svh"

module raf_div import raf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [AVG_W-1:0] quotient
);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[AVG_W-1:0];

   `RAF_ASSERT_NOW(a_busy_not_done, clock, reset, busy_ff, !done_ff, "divider busy and done")

endmodule

### sv/raf_dp.sv
// Datapath: sample ring, running sum, slot and fill count, divider, result register.
`include "running_average_filter_assert.svh"

module raf_dp import raf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  raf_cmd_type      cmd,
   output raf_status_type   status,
   input  logic [AVG_W-1:0] req_sample,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [AVG_W-1:0] rsp_average
);

   logic [AVG_W-1:0] store_ff [WINDOW];
   logic [AVG_W-1:0] sample_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [AVG_W-1:0] oldest;
   logic             full;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0] average_ff;
   logic             div_done;
   logic [AVG_W-1:0] quotient;

   // slots at or above the fill count were never written and read as zero
   assign full    = (fill_ff == CNT_W'(WINDOW));
   assign oldest  = full ? store_ff[slot_ff] : '0;
   assign sum_in  = sum_ff - SUM_W'(oldest) + SUM_W'(sample_ff);
   assign slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
   assign fill_in = full ? fill_ff : fill_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
      end
      if (cmd.update) begin
         store_ff[slot_ff] <= sample_ff;
      end
      if (cmd.load_out) begin
         average_ff <= quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         slot_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.update) begin
         sum_ff  <= sum_in;
         slot_ff <= slot_in;
         fill_ff <= fill_in;
      end
   end

   raf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.update),
      .dividend (sum_in),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average     = average_ff;

   `RAF_ASSERT_NOW(a_fill_range, clock, reset, 1'b1, fill_ff <= CNT_W'(WINDOW), "fill count above window")
   `RAF_ASSERT_NOW(a_slot_tracks_fill, clock, reset, !full, CNT_W'(slot_ff) == fill_ff, "slot and fill disagree while filling")
   `RAF_ASSERT_NEXT(a_load_needs_done, clock, reset, cmd.update, !div_done, "divider done right after start")

endmodule

### sv/raf_ctrl.sv
// Controller: sequences capture, update, divide and result load.
module raf_ctrl import raf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output raf_cmd_type    cmd,
   input  raf_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_DIVIDE = 3'b100
   } raf_state_type;

   raf_state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.update   = 1'b0;
      cmd.load_out = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done && status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/running_average_filter.sv
// Top level of the running average filter.
//
// Each accepted 16-bit sample replaces the oldest of the last 20 samples and
// yields one result: the truncated mean of the samples stored so far (fewer
// than 20 until the ring has filled). After acceptance the ring and sum are
// updated, the bit-serial divider runs (one quotient bit per cycle over the
// 21-bit sum) and then the result register loads. The next sample is not
// accepted until that result has loaded. The result register lets the next
// sample be accepted while a result still waits; a stalled result holds up
// the load of the following one. No clearing pass is needed after reset.
module running_average_filter import raf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [AVG_W-1:0] req_sample,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [AVG_W-1:0] rsp_average
);

   raf_cmd_type    cmd;
   raf_status_type status;

   raf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   raf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average)
   );

endmodule
